/* hdl/mfet_pkg.sv */
package mfet_pkg;

	// Slot geometry: two buses, each with its own row of motor slots.
	localparam int MOTOR_IDS     = 7;
	localparam int SLOTS_PER_BUS = 8;
	localparam int SLOT_COUNT    = 2 * SLOTS_PER_BUS;
	localparam int SLOT_W        = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
	localparam int IDX_LIMIT     = (MOTOR_IDS < SLOTS_PER_BUS) ? MOTOR_IDS : SLOTS_PER_BUS;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BASE_ID    = 2'd0;
	localparam logic [1:0] CFG_ENC_RANGE  = 2'd1;
	localparam logic [1:0] CFG_HALF_RANGE = 2'd2;

	// Configuration reset values.
	localparam logic [10:0] BASE_ID_RST    = 11'd513;
	localparam logic [14:0] ENC_RANGE_RST  = 15'd8191;
	localparam logic [14:0] HALF_RANGE_RST = 15'd4096;

	typedef struct packed {
		logic [10:0] base_id;
		logic [14:0] encoder_range;
		logic [14:0] half_range;
	} mfet_cfg_t;

	typedef struct packed {
		logic        bus;
		logic [10:0] frame_id;
		logic [63:0] payload;
	} mfet_in_t;

	typedef struct packed {
		logic               out_bus;
		logic [2:0]         motor_index;
		logic [15:0]        angle;
		logic signed [15:0] speed;
		logic signed [15:0] current;
		logic [7:0]         temperature;
		logic signed [15:0] angle_change;
		logic signed [31:0] total_angle;
	} mfet_out_t;

	// Slot update request from the frame stage to the slot store.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       angle;
	} mfet_upd_t;

endpackage

/* hdl/mfet_slot_track.sv */
module mfet_slot_track (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mfet_pkg::mfet_cfg_t     cfg,
	input  mfet_pkg::mfet_upd_t     upd,
	output logic signed [15:0]      angle_change,
	output logic signed [31:0]      total_angle
);
	import mfet_pkg::*;

	logic [15:0]        last_q  [SLOT_COUNT];
	logic [31:0]        total_q [SLOT_COUNT];
	logic [15:0]        diff;
	logic signed [16:0] diff_ext;
	logic signed [16:0] half_ext;
	logic signed [16:0] range_ext;
	logic signed [16:0] adj;

	// Raw change against the slot's previous angle, then unwrap by one turn.
	always_comb begin
		diff      = upd.angle - last_q[upd.slot];
		diff_ext  = signed'({diff[15], diff});
		half_ext  = signed'({2'b00, cfg.half_range});
		range_ext = signed'({2'b00, cfg.encoder_range});
		if (diff_ext > half_ext) begin
			adj = diff_ext - range_ext;
		end else if (diff_ext < -half_ext) begin
			adj = diff_ext + range_ext;
		end else begin
			adj = diff_ext;
		end
		angle_change = adj[15:0];
		total_angle  = signed'(total_q[upd.slot] + {{16{adj[15]}}, adj[15:0]});
	end

	// Slot store: read-modify-write of one slot per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				last_q[i]  <= '0;
				total_q[i] <= '0;
			end
		end else if (upd.en) begin
			last_q[upd.slot]  <= upd.angle;
			total_q[upd.slot] <= total_angle;
		end
	end

endmodule

/* hdl/motor_feedback_encoder_tracker_unit.sv */
// Motor feedback encoder tracker.
// The frame channel (frame_valid/frame_ready/frame) takes one received feedback
// word: bus, 11-bit identifier and eight data bytes. A frame whose identifier
// falls in base_id .. base_id+6 updates its motor slot and yields one word on
// the result channel (result_valid/result_ready/result); any other frame is
// dropped without a result.
// A frame is registered in the frame stage; a matching frame then loads the
// result register, which drives result_valid, once that register can take it.
// Throughput: one frame per cycle; the slot store does one read-modify-write
// per cycle, and a frame for the same slot in the next cycle sees the update.
// When the receiver stalls, the result register holds its word and the frame
// stage holds one more frame; frame_ready drops only when both are full.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; the user must make writes only while the block is idle (unchecked).
// Reset clears both channels, restores the configuration defaults and clears
// every slot's last angle and running total at once, so frames are accepted
// from the first cycle after reset.
module motor_feedback_encoder_tracker_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	output logic                  frame_ready,
	input  mfet_pkg::mfet_in_t    frame,
	output logic                  result_valid,
	input  logic                  result_ready,
	output mfet_pkg::mfet_out_t   result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [14:0]           cfg_data
);
	import mfet_pkg::*;

	mfet_cfg_t          cfg_q;
	logic               valid_s1;
	mfet_in_t           frame_s1;
	logic [11:0]        idx_ext;
	logic               hit;
	logic               advance;
	mfet_upd_t          upd;
	logic signed [15:0] angle_change;
	logic signed [31:0] total_angle;
	logic               result_valid_q;
	mfet_out_t          result_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_id       <= BASE_ID_RST;
			cfg_q.encoder_range <= ENC_RANGE_RST;
			cfg_q.half_range    <= HALF_RANGE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BASE_ID:    cfg_q.base_id       <= cfg_data[10:0];
				CFG_ENC_RANGE:  cfg_q.encoder_range <= cfg_data;
				CFG_HALF_RANGE: cfg_q.half_range    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame stage register.
	assign frame_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			frame_s1 <= frame;
		end
	end

	// Identifier window match and slot selection.
	always_comb begin
		idx_ext  = {1'b0, frame_s1.frame_id} - {1'b0, cfg_q.base_id};
		hit      = valid_s1 && !idx_ext[11] && (idx_ext[10:0] < 11'(IDX_LIMIT));
		advance  = valid_s1 && (!hit || !result_valid_q || result_ready);
		upd.en   = advance && hit;
		upd.slot = SLOT_W'(SLOT_W'(frame_s1.bus) * SLOT_W'(SLOTS_PER_BUS)
			+ SLOT_W'(idx_ext[10:0]));
		upd.angle = frame_s1.payload[63:48];
	end

	mfet_slot_track u_slot_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.upd          (upd),
		.angle_change (angle_change),
		.total_angle  (total_angle)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (upd.en) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			result_q.out_bus      <= frame_s1.bus;
			result_q.motor_index  <= idx_ext[2:0];
			result_q.angle        <= frame_s1.payload[63:48];
			result_q.speed        <= signed'(frame_s1.payload[47:32]);
			result_q.current      <= signed'(frame_s1.payload[31:16]);
			result_q.temperature  <= frame_s1.payload[15:8];
			result_q.angle_change <= angle_change;
			result_q.total_angle  <= total_angle;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// An empty result register never holds back the frame stage.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> frame_ready)
		else $error("frame stage stalled with an empty result register");

	// A matching frame that leaves the frame stage always produces a word.
	a_hit_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en |=> result_valid_q)
		else $error("matching frame produced no result word");

	// A taken word is not repeated unless a new match arrived.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_ready && !upd.en) |=> !result_valid_q)
		else $error("result word repeated after it was taken");
`endif

endmodule
